// ----- rtl/fir_bp_pkg.sv -----
// fir_bp_pkg: shared constants and the Q18 band-pass coefficient table
// for the 64-tap FIR filter. No dependencies.
package fir_bp_pkg;

   localparam int TAPS_DEFAULT      = 64;
   localparam int COEF_FRAC_DEFAULT = 18;
   localparam int OUT_SHIFT_DEFAULT = 4;

   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 16;
   localparam int PROD_W    = SAMPLE_W + COEF_W;
   localparam int LEVEL_W   = 12;
   localparam int UNIT_W    = 16;
   localparam int TABLE_LEN = 64;
   localparam int TABLE_IW  = 8;
   localparam logic [UNIT_W-1:0] UNIT_MAX = '1;
   localparam logic [UNIT_W-1:0] OFFSET   = 16'h8000;

   localparam logic signed [COEF_W-1:0] COEF_TABLE [TABLE_LEN] = '{
        16'sd1918,   16'sd2822,   16'sd3514,   16'sd3785,
        16'sd3496,   16'sd2629,   16'sd1305,   -16'sd233,
       -16'sd1667,  -16'sd2675,  -16'sd3019,  -16'sd2620,
       -16'sd1599,   -16'sd274,    16'sd891,   16'sd1394,
         16'sd804,  -16'sd1105,  -16'sd4270,  -16'sd8302,
      -16'sd12523, -16'sd16071, -16'sd18063, -16'sd17771,
      -16'sd14798,  -16'sd9187,  -16'sd1459,   16'sd7441,
       16'sd16295,  16'sd23807,  16'sd28837,  16'sd30606,
       16'sd28837,  16'sd23807,  16'sd16295,   16'sd7441,
       -16'sd1459,  -16'sd9187, -16'sd14798, -16'sd17771,
      -16'sd18063, -16'sd16071, -16'sd12523,  -16'sd8302,
       -16'sd4270,  -16'sd1105,    16'sd804,   16'sd1394,
         16'sd891,   -16'sd274,  -16'sd1599,  -16'sd2620,
       -16'sd3019,  -16'sd2675,  -16'sd1667,   -16'sd233,
        16'sd1305,   16'sd2629,   16'sd3496,   16'sd3785,
        16'sd3514,   16'sd2822,   16'sd1918,   16'sd1026
   };

   function automatic logic signed [COEF_W-1:0] coef_at(input logic [TABLE_IW-1:0] idx);
      logic signed [COEF_W-1:0] c;
      c = '0;
      if (idx < TABLE_IW'(TABLE_LEN)) begin
         c = COEF_TABLE[idx[5:0]];
      end
      return c;
   endfunction

endpackage

// ----- rtl/fir_bandpass_64tap.sv -----
// After the input transfer, every tap is read, multiplied and accumulated, and
// then the result is offered; no new item is taken before that. The single shared
// multiply-accumulate unit steps through one tap per cycle.
// A new item may be accepted while the previous result still waits.
// Reset (synchronous, active high) empties the delay line to all zero
// through per-entry valid bits and drops any pending result.
//
// fir_bandpass_64tap: top level of the direct-form FIR filter, circular
// delay-line memory, tap sequencer and MAC. Depends on fir_bp_pkg.
module fir_bandpass_64tap #(
   parameter int TAPS           = fir_bp_pkg::TAPS_DEFAULT,
   parameter int COEF_FRAC_BITS = fir_bp_pkg::COEF_FRAC_DEFAULT,
   parameter int OUT_SHIFT      = fir_bp_pkg::OUT_SHIFT_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [fir_bp_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic        [fir_bp_pkg::LEVEL_W-1:0]     rsp_level
);

   localparam int PW     = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int SUM_W  = fir_bp_pkg::PROD_W + $clog2(TAPS + 1);
   localparam int BIAS_W = fir_bp_pkg::UNIT_W + COEF_FRAC_BITS;
   localparam int ACC_W  = ((SUM_W > BIAS_W) ? SUM_W : BIAS_W) + 2;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_RUN   = 4'b0010,
      S_DRAIN = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [fir_bp_pkg::SAMPLE_W-1:0] mem [TAPS];
   logic [TAPS-1:0]                 vld_ff;
   logic [PW-1:0]                   wptr_ff, rptr_ff, cnt_ff;
   logic [fir_bp_pkg::SAMPLE_W-1:0] rd_data_ff;
   logic                            rd_vld_ff;
   logic signed [fir_bp_pkg::COEF_W-1:0] coef_ff;
   logic                            s1_vld_ff, s2_vld_ff;
   logic signed [fir_bp_pkg::PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]         acc_ff;
   logic                            rsp_valid_ff;
   logic [fir_bp_pkg::LEVEL_W-1:0]  rsp_level_ff;

   logic                            req_xfer, out_free, issue;
   logic signed [fir_bp_pkg::SAMPLE_W-1:0] tap_sample;
   logic signed [ACC_W-1:0]         biased, shifted;
   logic [fir_bp_pkg::UNIT_W-1:0]   unit_val;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign issue     = (state_ff == S_RUN);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) state_in = S_RUN;
         end
         S_RUN: begin
            if (cnt_ff == PW'(TAPS - 1)) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         vld_ff    <= '0;
         wptr_ff   <= '0;
         rptr_ff   <= '0;
         cnt_ff    <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
         if (req_xfer) begin
            vld_ff[wptr_ff] <= 1'b1;
            rptr_ff         <= wptr_ff;
            wptr_ff         <= (wptr_ff == PW'(TAPS - 1)) ? '0 : wptr_ff + 1'b1;
            cnt_ff          <= '0;
         end else if (issue) begin
            rptr_ff <= (rptr_ff == '0) ? PW'(TAPS - 1) : rptr_ff - 1'b1;
            cnt_ff  <= cnt_ff + 1'b1;
         end
      end
   end

   // delay-line memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         mem[wptr_ff] <= req_sample;
      end
      rd_data_ff <= mem[rptr_ff];
      rd_vld_ff  <= vld_ff[rptr_ff];
      coef_ff    <= fir_bp_pkg::coef_at(fir_bp_pkg::TABLE_IW'(cnt_ff));
   end

   assign tap_sample = rd_vld_ff ? $signed(rd_data_ff) : '0;

   always_ff @(posedge clock) begin
      prod_ff <= tap_sample * coef_ff;
      if (req_xfer) begin
         acc_ff <= '0;
      end else if (s2_vld_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // offset, floor shift, saturate
   always_comb begin
      biased  = acc_ff + $signed({{(ACC_W - BIAS_W){1'b0}}, fir_bp_pkg::OFFSET,
                                  {COEF_FRAC_BITS{1'b0}}});
      shifted = biased >>> COEF_FRAC_BITS;
      if (biased[ACC_W-1]) begin
         unit_val = '0;
      end else if (|shifted[ACC_W-1:fir_bp_pkg::UNIT_W]) begin
         unit_val = fir_bp_pkg::UNIT_MAX;
      end else begin
         unit_val = shifted[fir_bp_pkg::UNIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && out_free) begin
         rsp_level_ff <= fir_bp_pkg::LEVEL_W'(unit_val >> OUT_SHIFT);
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> (cnt_ff <= PW'(TAPS - 1)))
      else $error("tap counter out of range");

   a_rptr_range: assert property (@(posedge clock) disable iff (reset)
      (rptr_ff <= PW'(TAPS - 1)) && (wptr_ff <= PW'(TAPS - 1)))
      else $error("delay-line pointer out of range");

   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> $past(s1_vld_ff))
      else $error("product stage valid without read stage");

   a_done_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result not presented after finishing");

   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (!s1_vld_ff && !s2_vld_ff))
      else $error("MAC pipeline not empty at completion");
`endif

endmodule
